[rtl/core/afodm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afodm_pkg: shared definitions of the fade-out / downmix block
// widths, register indexes, reset values, op codes, state and lane control types
// ----------------------------------------------------------------------------
package afodm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_BITS        = 32;
    localparam int FADE_BITS       = 24;
    localparam int CFG_IDX_BITS    = 2;

    typedef logic [CFG_IDX_BITS-1:0] t_reg_idx;

    localparam t_reg_idx REG_TOTAL_LEN = 2'd0;
    localparam t_reg_idx REG_FADE_LEN  = 2'd1;
    localparam t_reg_idx REG_MONO_MODE = 2'd2;

    localparam logic [LEN_BITS-1:0]  TOTAL_LEN_RST = 32'd8640000;
    localparam logic [FADE_BITS-1:0] FADE_LEN_RST  = 24'd480000;

    // input op codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic div_first;
    } t_lane_ctl;

endpackage
`default_nettype wire

[rtl/core/afodm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afodm_in_if: input word channel
// valid/ready handshake carrying op and one stereo sample frame
// ----------------------------------------------------------------------------
interface afodm_in_if
    import afodm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output op, output left_in, output right_in, input ready);
    modport sink   (input valid, input op, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

[rtl/core/afodm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afodm_out_if: result word channel
// valid/ready handshake carrying one faded frame and the final-frame flag
// ----------------------------------------------------------------------------
interface afodm_out_if
    import afodm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          final_frame;

    modport source (output valid, output left_out, output right_out, output final_frame,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input final_frame,
                    output ready);
endinterface
`default_nettype wire

[rtl/core/afodm_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afodm_lane: serial gain lane
// bit-serial multiply of |sample| by the frame count, then restoring divide
// by the fade length, one quotient bit a cycle, sign restored at the end
// ----------------------------------------------------------------------------
module afodm_lane
    import afodm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire t_lane_ctl                     i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_mbit,
    input  wire logic [FADE_BITS-1:0]          i_fade,
    output logic signed [SAMPLE_BITS-1:0]      o_sample,
    output logic signed [SAMPLE_BITS-1:0]      o_scaled
);
    localparam int ACC_W = SAMPLE_BITS + FADE_BITS;

    logic                          r_neg;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic [ACC_W-1:0]              r_acc;
    logic [FADE_BITS-1:0]          r_rem;

    logic [SAMPLE_BITS:0]          w_sum;
    logic [FADE_BITS-1:0]          w_rsrc;
    logic [FADE_BITS:0]            w_trial;
    logic [FADE_BITS:0]            w_diff;
    logic                          w_ge;

    // multiply: add into the top, shift right through the low part
    assign w_sum = {1'b0, r_acc[ACC_W-1:FADE_BITS]}
                 + (i_mbit ? {1'b0, r_mag} : {(SAMPLE_BITS+1){1'b0}});

    // divide: upper product bits are already below the divisor
    assign w_rsrc  = i_ctl.div_first ? r_acc[ACC_W-1:SAMPLE_BITS] : r_rem;
    assign w_trial = {w_rsrc, r_acc[SAMPLE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, i_fade};
    assign w_ge    = (w_trial >= {1'b0, i_fade});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_smp <= i_sample;
            r_neg <= i_sample[SAMPLE_BITS-1];
            r_mag <= i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
            r_acc <= '0;
        end else if (i_ctl.mul_step) begin
            r_acc <= {w_sum, r_acc[FADE_BITS-1:1]};
        end else if (i_ctl.div_step) begin
            r_rem <= w_ge ? w_diff[FADE_BITS-1:0] : w_trial[FADE_BITS-1:0];
            r_acc[SAMPLE_BITS-1:0] <= {r_acc[SAMPLE_BITS-2:0], w_ge};
        end
    end

    assign o_sample = r_smp;
    assign o_scaled = r_neg ? (~r_acc[SAMPLE_BITS-1:0] + 1'b1) : r_acc[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

[rtl/core/audio_fade_out_downmix.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fade_out_downmix: track countdown with linear fade-out and mono mix
// counts frames of a track down from total_len and scales the last
// fade_len frames by frames_left / fade_len, optionally mixing to mono
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  i_in      in   valid / ready    op, left_in, right_in
//  o_out     out  valid / ready    left_out, right_out, final_frame
//  i_cfg_*   in   write enable     register index, write data
//
//  a faded frame loads both lanes, runs the 24-step serial multiply by the
//  frame count and the SAMPLE_BITS-step restoring divide by fade_len, then
//  waits for the output slot; both lanes run side by side
//  a unity-gain frame skips the lanes; a start word or idle frame stays in idle
//  synchronous active-low reset clears the countdown, the state and the
//  result valid, and restores the register reset values
//  a result waiting in the output register does not stop the next word
//  being taken; only the hand-over from the lanes waits for the slot
// ----------------------------------------------------------------------------
module audio_fade_out_downmix
    import afodm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    afodm_in_if.sink                  i_in,
    afodm_out_if.source               o_out,
    input  wire logic                 i_cfg_we,
    input  wire t_reg_idx             i_cfg_idx,
    input  wire logic [LEN_BITS-1:0]  i_cfg_data
);
    localparam int MAX_STEPS = (FADE_BITS > SAMPLE_BITS) ? FADE_BITS : SAMPLE_BITS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    // configuration registers
    logic [LEN_BITS-1:0]  r_total_len;
    logic [FADE_BITS-1:0] r_fade_len;
    logic                 r_mono;

    // countdown and sequencer
    logic [LEN_BITS-1:0]  r_frames_left;
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [FADE_BITS-1:0] r_mult;
    logic                 r_unity;
    logic                 r_final;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_final;

    logic                          w_in_acc;
    logic                          w_frame_go;
    logic                          w_slot_free;
    logic                          w_unload;
    logic                          w_ready;
    t_lane_ctl                     w_ctl;

    logic signed [SAMPLE_BITS:0]   w_mix_sum;
    logic signed [SAMPLE_BITS:0]   w_mix_adj;
    logic signed [SAMPLE_BITS-1:0] w_left_src;

    logic signed [SAMPLE_BITS-1:0] w_l_smp, w_l_scl, w_r_smp, w_r_scl;

    assign w_in_acc    = i_in.valid && w_ready;
    // a sample frame that counts: a track is still running
    assign w_frame_go  = w_in_acc && (i_in.op == OP_FRAME) && (r_frames_left != '0);
    assign w_slot_free = !r_out_valid || o_out.ready;

    // mono mix, truncated toward zero
    assign w_mix_sum  = {i_in.left_in[SAMPLE_BITS-1], i_in.left_in}
                      + {i_in.right_in[SAMPLE_BITS-1], i_in.right_in};
    assign w_mix_adj  = w_mix_sum + {{SAMPLE_BITS{1'b0}}, w_mix_sum[SAMPLE_BITS]};
    assign w_left_src = r_mono ? w_mix_adj[SAMPLE_BITS:1] : i_in.left_in;

    // ---- configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_len <= TOTAL_LEN_RST;
            r_fade_len  <= FADE_LEN_RST;
            r_mono      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOTAL_LEN: r_total_len <= i_cfg_data;
                REG_FADE_LEN:  r_fade_len  <= i_cfg_data[FADE_BITS-1:0];
                REG_MONO_MODE: r_mono      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_frame_go) begin
                    // unity gain skips the serial lanes
                    if ((r_fade_len == '0) || (r_frames_left > {8'd0, r_fade_len})) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (r_cnt == '0) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == '0) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- outputs of the sequencer
    always_comb begin
        w_ready  = 1'b0;
        w_unload = 1'b0;
        w_ctl    = '0;
        case (r_state)
            ST_IDLE: begin
                w_ready  = 1'b1;
                w_ctl.load = w_frame_go;
            end
            ST_MUL: begin
                w_ctl.mul_step = 1'b1;
            end
            ST_DIV: begin
                w_ctl.div_step  = 1'b1;
                w_ctl.div_first = (r_cnt == CNT_W'(SAMPLE_BITS - 1));
            end
            ST_FIN: begin
                w_unload = w_slot_free;
            end
            default: ;
        endcase
    end

    assign i_in.ready = w_ready;

    // ---- sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frames_left <= '0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && (i_in.op == OP_START)) begin
                r_frames_left <= r_total_len;
            end else if (w_frame_go) begin
                r_frames_left <= r_frames_left - 1'b1;
            end
            if (r_state == ST_IDLE) begin
                r_cnt <= CNT_W'(FADE_BITS - 1);
            end else if ((r_state == ST_MUL) && (r_cnt == '0)) begin
                r_cnt <= CNT_W'(SAMPLE_BITS - 1);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // frame payload: multiplier bits shift out lsb first
    always_ff @(posedge i_clk) begin
        if (w_frame_go) begin
            r_mult  <= r_frames_left[FADE_BITS-1:0];
            r_unity <= (r_fade_len == '0) || (r_frames_left > {8'd0, r_fade_len});
            r_final <= (r_frames_left == LEN_BITS'(1));
        end else if (r_state == ST_MUL) begin
            r_mult <= {1'b0, r_mult[FADE_BITS-1:1]};
        end
    end

    // ---- gain lanes
    afodm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (w_left_src),
        .i_mbit   (r_mult[0]),
        .i_fade   (r_fade_len),
        .o_sample (w_l_smp),
        .o_scaled (w_l_scl)
    );

    afodm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (i_in.right_in),
        .i_mbit   (r_mult[0]),
        .i_fade   (r_fade_len),
        .o_sample (w_r_smp),
        .o_scaled (w_r_scl)
    );

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_unload) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_unload) begin
            r_out_left  <= r_unity ? w_l_smp : w_l_scl;
            // right channel held at zero in mono mode
            r_out_right <= r_mono ? '0 : (r_unity ? w_r_smp : w_r_scl);
            r_out_final <= r_final;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_out    = r_out_left;
    assign o_out.right_out   = r_out_right;
    assign o_out.final_frame = r_out_final;

endmodule
`default_nettype wire

[rtl/core/afodm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afodm_checker: port-level checks of the fade-out block
// handshake holding on the result channel and word timing across channels
// ----------------------------------------------------------------------------
module afodm_checker
    import afodm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_in_op,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_out_left,
    input wire logic [SAMPLE_BITS-1:0] i_out_right,
    input wire logic                   i_out_final
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // and its word does not move
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_out_valid) && !$past(i_out_ready)
        |-> $stable(i_out_left) && $stable(i_out_right) && $stable(i_out_final))
        else $error("result word changed while stalled");

    // a new result never follows an accepted word in the very next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result appeared without processing time");

    // a start word completes at once
    a_start_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_START) |=> i_in_ready)
        else $error("input not ready after start word");

endmodule

bind audio_fade_out_downmix afodm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_afodm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.left_out),
    .i_out_right (o_out.right_out),
    .i_out_final (o_out.final_frame)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for audio_fade_out_downmix
// drives start and frame words through the input channel, keeps its own
// countdown and fade arithmetic, and compares every result word in order
// under several source idle and sink stall mixes
// ----------------------------------------------------------------------------
module testbench;
    import afodm_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int SETTLE_CYCLES = 64;       // longer than one faded frame
    localparam int CYCLE_LIMIT   = 400000;
    localparam longint SMP_HI    = (longint'(1) <<< (SB - 1)) - 1;
    localparam longint SMP_LO    = -SMP_HI - 1;

    // index past the register list, writes to it must be dropped
    localparam t_reg_idx REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic                 last;
    } t_faded_frame;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_reg_idx             cfg_idx;
    logic [LEN_BITS-1:0]  cfg_data;

    afodm_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    afodm_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    audio_fade_out_downmix #(.SAMPLE_BITS(SB)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // own copy of the registers and the countdown
    logic [LEN_BITS-1:0]  trk_total_len;
    logic [FADE_BITS-1:0] trk_fade_len;
    logic                 trk_mono;
    logic [LEN_BITS-1:0]  trk_frames_left;

    t_faded_frame faded_frames_due[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int words_used    = 0;   // starts and frames that produced a result
    int tracks_started = 0;
    int window_frames = 0;
    int final_frames  = 0;
    int frames_checked = 0;
    int frame_errors  = 0;
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still due", cycle_count,
                 faded_frames_due.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // fade arithmetic: exact product, truncating divide, clamp
    // ------------------------------------------------------------------
    function automatic longint clamp_sample(input longint v);
        if (v > SMP_HI) return SMP_HI;
        if (v < SMP_LO) return SMP_LO;
        return v;
    endfunction

    function automatic logic signed [SB-1:0] fade_sample(input longint s,
                                                         input logic [LEN_BITS-1:0] left);
        longint v;
        v = s;
        if (trk_fade_len != '0 && left <= LEN_BITS'(trk_fade_len))
            v = (s * longint'(left)) / longint'(trk_fade_len);
        v = clamp_sample(v);
        return v[SB-1:0];
    endfunction

    // advance the countdown for one accepted word, queue the frame it yields
    task automatic fade_track_word(input logic op, input logic signed [SB-1:0] l,
                                   input logic signed [SB-1:0] r);
        t_faded_frame f;
        longint mix;
        if (op == OP_START) begin
            trk_frames_left = trk_total_len;
            tracks_started++;
            words_used++;
        end else if (trk_frames_left != '0) begin
            if (trk_mono) begin
                // average with truncation toward zero before the gain
                mix     = clamp_sample((longint'(l) + longint'(r)) / 2);
                f.left  = fade_sample(mix, trk_frames_left);
                f.right = '0;
            end else begin
                f.left  = fade_sample(longint'(l), trk_frames_left);
                f.right = fade_sample(longint'(r), trk_frames_left);
            end
            f.last = (trk_frames_left == 1);
            if (trk_fade_len != '0 && trk_frames_left <= LEN_BITS'(trk_fade_len))
                window_frames++;
            if (f.last)
                final_frames++;
            trk_frames_left = trk_frames_left - 1;
            faded_frames_due.push_back(f);
            words_used++;
        end
        // a frame with no track running is dropped and changes nothing
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, in-order compare
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        t_faded_frame want;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (faded_frames_due.size() == 0) begin
                    frame_errors++;
                    $display("%0t: unexpected result word, actual L=%0d R=%0d final=%0b",
                             $realtime, out_ch.left_out, out_ch.right_out,
                             out_ch.final_frame);
                end else begin
                    want = faded_frames_due.pop_front();
                    frames_checked++;
                    if (out_ch.left_out !== want.left || out_ch.right_out !== want.right ||
                        out_ch.final_frame !== want.last) begin
                        frame_errors++;
                        $display("%0t: mismatch, expected L=%0d R=%0d final=%0b, actual L=%0d R=%0d final=%0b",
                                 $realtime, want.left, want.right, want.last,
                                 out_ch.left_out, out_ch.right_out, out_ch.final_frame);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // source side helpers
    // ------------------------------------------------------------------
    // one word through the input channel, valid held high across back-to-back words
    task automatic send_word(input logic op, input logic signed [SB-1:0] l,
                             input logic signed [SB-1:0] r);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        fade_track_word(op, l, r);
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (faded_frames_due.size() != 0)
            @(posedge i_clk);
    endtask

    // block idle: nothing due and any dropped word long finished
    task automatic settle();
        hold_off();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [LEN_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_TOTAL_LEN: trk_total_len = data;
            REG_FADE_LEN:  trk_fade_len  = data[FADE_BITS-1:0];
            REG_MONO_MODE: trk_mono      = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_track(input logic [LEN_BITS-1:0] total, input logic [FADE_BITS-1:0] fade,
                             input logic mono);
        write_reg(REG_TOTAL_LEN, total);
        write_reg(REG_FADE_LEN, {8'h00, fade});
        write_reg(REG_MONO_MODE, {31'd0, mono});
    endtask

    // extremes and small values turn up often, the rest is uniform
    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_HI[SB-1:0];
            1: return SMP_LO[SB-1:0];
            2: return '0;
            3: return '1;
            default: return SB'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset values: long track, fade far off, so unity gain
    task automatic test_reset_defaults();
        send_word(OP_FRAME, 16'sd1234, -16'sd1234);     // no track yet, dropped
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_LO[SB-1:0]);
        send_word(OP_FRAME, SMP_LO[SB-1:0], SMP_HI[SB-1:0]);
        settle();
    endtask

    // one unity frame above the window, then the ramp down to 1/fade_len
    task automatic test_fade_ramp();
        set_track(32'd5, 24'd4, 1'b0);
        send_word(OP_START, '1, '1);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_LO[SB-1:0]);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_LO[SB-1:0]);
        send_word(OP_FRAME, -16'sd7, 16'sd7);
        send_word(OP_FRAME, SMP_LO[SB-1:0], SMP_HI[SB-1:0]);
        send_word(OP_FRAME, -16'sd3, 16'sd3);          // final frame
        send_word(OP_FRAME, 16'sd100, 16'sd100);       // track over, dropped
        settle();
    endtask

    // mono mix, right output forced to zero
    task automatic test_mono_mix();
        set_track(32'd3, 24'd3, 1'b1);
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_HI[SB-1:0]);
        send_word(OP_FRAME, SMP_LO[SB-1:0], SMP_LO[SB-1:0]);
        send_word(OP_FRAME, -16'sd1, 16'sd0);
        settle();
    endtask

    // zero fade, restart mid-track, zero-length track
    task automatic test_special_cases();
        set_track(32'd2, 24'd0, 1'b0);
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_LO[SB-1:0]);
        send_word(OP_START, '0, '0);                   // reload while running
        send_word(OP_FRAME, SMP_LO[SB-1:0], 16'sd5);
        send_word(OP_FRAME, 16'sd9, SMP_HI[SB-1:0]);
        settle();
        write_reg(REG_TOTAL_LEN, 32'd0);
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, 16'sd11, 16'sd12);         // nothing running
        settle();
    endtask

    // widest register values, bits above a register dropped, unused index
    task automatic test_register_extremes();
        write_reg(REG_TOTAL_LEN, 32'hFFFF_FFFF);
        write_reg(REG_FADE_LEN, 32'hFFFF_FFFF);
        write_reg(REG_MONO_MODE, 32'hFFFF_FFFE);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, SMP_HI[SB-1:0], SMP_LO[SB-1:0]);
        settle();
        write_reg(REG_TOTAL_LEN, 32'd3);
        send_word(OP_START, '0, '0);
        send_word(OP_FRAME, SMP_LO[SB-1:0], SMP_HI[SB-1:0]);
        settle();
    endtask

    // mostly whole tracks with random content, some restarts and pauses
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int quota);
        int goal;
        int n_frames;
        int roll;
        logic [LEN_BITS-1:0]  total;
        logic [FADE_BITS-1:0] fade;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        goal = words_used + quota;
        while (words_used < goal) begin
            settle();
            roll = $urandom_range(0, 19);
            if (roll == 0)      total = '0;
            else if (roll == 1) total = 32'hFFFF_FFFF;
            else                total = $urandom_range(1, 40);
            roll = $urandom_range(0, 19);
            if (roll < 2)       fade = '0;
            else if (roll == 2) fade = 24'hFF_FFFF;
            else if (roll == 3) fade = FADE_BITS'($urandom());
            else                fade = FADE_BITS'($urandom_range(1, 48));
            write_reg(REG_TOTAL_LEN, total);
            write_reg(REG_FADE_LEN, {8'($urandom()), fade});
            write_reg(REG_MONO_MODE, {31'($urandom()), 1'($urandom())});
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, $urandom());
            repeat ($urandom_range(1, 3)) begin
                send_word(OP_START, pick_sample(), pick_sample());
                if (trk_total_len > 40)
                    n_frames = $urandom_range(4, 24);
                else
                    n_frames = trk_total_len + $urandom_range(0, 2);
                for (int k = 0; k < n_frames; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 4) begin
                        send_word(OP_START, pick_sample(), pick_sample());
                    end else if (roll < 7) begin
                        // source waits until the block has handed back everything
                        hold_off();
                        wait_drained();
                    end
                    send_word(OP_FRAME, pick_sample(), pick_sample());
                end
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_FRAME;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_TOTAL_LEN;
        cfg_data       = '0;
        trk_total_len   = TOTAL_LEN_RST;
        trk_fade_len    = FADE_LEN_RST;
        trk_mono        = 1'b0;
        trk_frames_left = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_fade_ramp();
        test_mono_mix();
        test_special_cases();
        test_register_extremes();

        test_random_traffic(0, 0, 80);
        test_random_traffic(61, 0, 80);
        test_random_traffic(0, 61, 80);
        test_random_traffic(30, 30, 80);

        $display("run covered %0d tracks and %0d checked frames, %0d inside a fade window",
                 tracks_started, frames_checked, window_frames);
        $display("%0d final frames seen, %0d mismatches, four idle and stall mixes",
                 final_frames, frame_errors);
        if (frame_errors == 0 && faded_frames_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
